// ----- rtl/core/mbet_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the escape-time pixel engine.
// No dependencies; every other file in rtl/core uses it by scoped names.
package mbet_pkg;

	localparam int FRAC_BITS_DEF  = 28;
	localparam int INDEX_BITS_DEF = 12;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ORIGIN_W   = 32;
	localparam int STEP_W     = 31;
	localparam int LIMIT_W    = 16;
	localparam int SHADE_W    = 8;
	localparam int COUNT_W    = LIMIT_W;
	localparam int OUT_DATA_W = SHADE_W + COUNT_W;

	// native multiplier chunk
	localparam int CHUNK_W = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_REAL = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_IMAG = CFG_ADDR_W'(1);
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_REAL   = CFG_ADDR_W'(2);
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_IMAG   = CFG_ADDR_W'(3);
	localparam logic [CFG_ADDR_W-1:0] REG_ITER_LIMIT  = CFG_ADDR_W'(4);
	localparam logic [CFG_ADDR_W-1:0] REG_SHADE_FACT  = CFG_ADDR_W'(5);

	localparam logic [ORIGIN_W-1:0] RST_ORIGIN_REAL = 32'hE000_0000;
	localparam logic [ORIGIN_W-1:0] RST_ORIGIN_IMAG = 32'hE800_0000;
	localparam logic [STEP_W-1:0]   RST_STEP_REAL   = 31'd196608;
	localparam logic [STEP_W-1:0]   RST_STEP_IMAG   = 31'd196608;
	localparam logic [LIMIT_W-1:0]  RST_ITER_LIMIT  = 16'd256;
	localparam logic [SHADE_W-1:0]  RST_SHADE_FACT  = 8'd1;

	localparam logic [SHADE_W-1:0] SHADE_MAX = 8'hFF;

	typedef struct packed {
		logic signed [ORIGIN_W-1:0] origin_real;
		logic signed [ORIGIN_W-1:0] origin_imag;
		logic [STEP_W-1:0]          step_real;
		logic [STEP_W-1:0]          step_imag;
		logic [LIMIT_W-1:0]         iteration_limit;
		logic [SHADE_W-1:0]         shade_factor;
	} cfg_t;

endpackage

// ----- rtl/core/mandelbrot_escape_time_pixel.sv -----
`timescale 1ns / 1ps
// Top level of the escape-time pixel engine: config registers, front end,
// queue and iteration engine. Uses mbet_pkg, mbet_front, mbet_queue, mbet_iter.
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid/s_tready         s_tdata: column, row
// m_*       out  m_tvalid/m_tready         m_tdata: shade, escape_count; m_tuser: inside_res
// cfg_*     in   cfg_we                    cfg_addr index, cfg_wdata value
//
// One z update runs abs, the multiply chunk pairs (NCH * NCH of them, with NCH =
// ceil((FRAC_BITS + 2) / 32), so one pair for FRAC_BITS up to 30), then combine;
// the back end's pace per pixel is set by that multiply loop.
// Front end (index*step, then + origin) overlaps the back end.
// Reset clears all control state and loads register defaults.
// A two-beat queue and an output register let each side stall on its own.
module mandelbrot_escape_time_pixel #(
	parameter int FRAC_BITS  = mbet_pkg::FRAC_BITS_DEF,
	parameter int INDEX_BITS = mbet_pkg::INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((2*INDEX_BITS+7)/8)*8-1:0] s_tdata,   // column, row
	output logic m_tvalid,
	input  logic m_tready,
	output logic [mbet_pkg::OUT_DATA_W-1:0] m_tdata,     // shade, escape_count
	output logic m_tuser,                                // inside_res
	input  logic cfg_we,
	input  logic [mbet_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [mbet_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CCW = INDEX_BITS + 33;

	mbet_pkg::cfg_t cfg_q;

	logic                  f_valid, f_ready, q_valid, q_ready;
	logic signed [CCW-1:0] f_cr, f_ci;
	logic [2*CCW-1:0]      q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real     <= mbet_pkg::RST_ORIGIN_REAL;
			cfg_q.origin_imag     <= mbet_pkg::RST_ORIGIN_IMAG;
			cfg_q.step_real       <= mbet_pkg::RST_STEP_REAL;
			cfg_q.step_imag       <= mbet_pkg::RST_STEP_IMAG;
			cfg_q.iteration_limit <= mbet_pkg::RST_ITER_LIMIT;
			cfg_q.shade_factor    <= mbet_pkg::RST_SHADE_FACT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mbet_pkg::REG_ORIGIN_REAL: cfg_q.origin_real <= $signed(cfg_wdata);
				mbet_pkg::REG_ORIGIN_IMAG: cfg_q.origin_imag <= $signed(cfg_wdata);
				mbet_pkg::REG_STEP_REAL:   cfg_q.step_real   <= cfg_wdata[30:0];
				mbet_pkg::REG_STEP_IMAG:   cfg_q.step_imag   <= cfg_wdata[30:0];
				mbet_pkg::REG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_wdata[15:0];
				mbet_pkg::REG_SHADE_FACT:  cfg_q.shade_factor    <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	mbet_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.column    (s_tdata[INDEX_BITS-1:0]),
		.row       (s_tdata[2*INDEX_BITS-1:INDEX_BITS]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_cr    (f_cr),
		.out_ci    (f_ci)
	);

	mbet_queue #(.W(2*CCW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_ci, f_cr}),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	mbet_iter #(.FRAC_BITS(FRAC_BITS), .INDEX_BITS(INDEX_BITS)) u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cr     ($signed(q_data[CCW-1:0])),
		.q_ci     ($signed(q_data[2*CCW-1:CCW])),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- rtl/core/mbet_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts pixel beats and maps column/row to the point c.
// Two stages (index*step, then + origin). Depends on mbet_pkg.
module mbet_front #(
	parameter int INDEX_BITS = mbet_pkg::INDEX_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mbet_pkg::cfg_t          cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [INDEX_BITS-1:0]   column,
	input  logic [INDEX_BITS-1:0]   row,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [INDEX_BITS+32:0] out_cr,
	output logic signed [INDEX_BITS+32:0] out_ci
);

	localparam int PW  = INDEX_BITS + mbet_pkg::STEP_W;
	localparam int CCW = INDEX_BITS + 33;

	logic          valid_s1, valid_s2;
	logic [PW-1:0] pr_s1, pi_s1;
	logic signed [CCW-1:0] cr_s2, ci_s2;
	logic          adv_s1, adv_s2;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			pr_s1 <= PW'(column) * PW'(cfg.step_real);
			pi_s1 <= PW'(row) * PW'(cfg.step_imag);
		end
		if (adv_s2 && valid_s1) begin
			cr_s2 <= CCW'(cfg.origin_real) + $signed({2'b00, pr_s1});
			ci_s2 <= CCW'(cfg.origin_imag) + $signed({2'b00, pi_s1});
		end
	end

	assign out_valid = valid_s2;
	assign out_cr    = cr_s2;
	assign out_ci    = ci_s2;

endmodule

// ----- rtl/core/mbet_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO between the front end and the iteration engine.
// Depth from mbet_pkg::QUEUE_DEPTH.
module mbet_queue #(
	parameter int W = 2 * (mbet_pkg::INDEX_BITS_DEF + 33)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int D  = mbet_pkg::QUEUE_DEPTH;
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	logic [W-1:0]  mem_q [D];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign in_ready  = count_q != CW'(D);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == AW'(D - 1)) ? '0 : wptr_q + AW'(1);
			if (pop) rptr_q <= (rptr_q == AW'(D - 1)) ? '0 : rptr_q + AW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_data;
	end

endmodule

// ----- rtl/core/mbet_mul.sv -----
`timescale 1ns / 1ps
// Chunked multiplier: a*a, b*b and a*b from 32x32 partial products,
// one chunk pair per cycle. Depends on mbet_pkg.
module mbet_mul #(
	parameter int MW = mbet_pkg::FRAC_BITS_DEF + 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic            done,
	output logic [2*MW-1:0] aa,
	output logic [2*MW-1:0] bb,
	output logic [2*MW-1:0] ab
);

	localparam int CH   = mbet_pkg::CHUNK_W;
	localparam int NCH  = (MW + CH - 1) / CH;
	localparam int PW   = NCH * CH;
	localparam int AW   = 2 * PW;
	localparam int SHW  = $clog2(AW);
	localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam logic [CNTW-1:0] LASTC = CNTW'(NCH - 1);

	logic [PW-1:0]   a_pad, b_pad;
	logic [CH-1:0]   a_x, a_y, b_x, b_y;
	logic [2*CH-1:0] aa_pp, bb_pp, ab_pp;
	logic [SHW-1:0]  sh;
	logic [CNTW-1:0] ia_q, ib_q;
	logic            busy_q, last;
	logic [AW-1:0]   aa_q, bb_q, ab_q;

	assign a_pad = PW'(a);
	assign b_pad = PW'(b);
	assign a_x   = a_pad[ia_q*CH +: CH];
	assign a_y   = a_pad[ib_q*CH +: CH];
	assign b_x   = b_pad[ia_q*CH +: CH];
	assign b_y   = b_pad[ib_q*CH +: CH];
	assign aa_pp = (2*CH)'(a_x) * (2*CH)'(a_y);
	assign bb_pp = (2*CH)'(b_x) * (2*CH)'(b_y);
	assign ab_pp = (2*CH)'(a_x) * (2*CH)'(b_y);
	assign sh    = SHW'((int'(ia_q) + int'(ib_q)) * CH);
	assign last  = (ia_q == LASTC) && (ib_q == LASTC);
	assign done  = busy_q && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ia_q   <= '0;
			ib_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			ia_q   <= '0;
			ib_q   <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else if (ia_q == LASTC) begin
				ia_q <= '0;
				ib_q <= ib_q + CNTW'(1);
			end else begin
				ia_q <= ia_q + CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			aa_q <= '0;
			bb_q <= '0;
			ab_q <= '0;
		end else if (busy_q) begin
			aa_q <= aa_q + (AW'(aa_pp) << sh);
			bb_q <= bb_q + (AW'(bb_pp) << sh);
			ab_q <= ab_q + (AW'(ab_pp) << sh);
		end
	end

	assign aa = aa_q[2*MW-1:0];
	assign bb = bb_q[2*MW-1:0];
	assign ab = ab_q[2*MW-1:0];

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("multiplier restarted while busy");

endmodule

// ----- rtl/core/mbet_iter.sv -----
`timescale 1ns / 1ps
// Back end: z = z*z + c iteration sequencer, escape test, shade and
// output register. Uses mbet_mul and mbet_pkg.
module mbet_iter #(
	parameter int FRAC_BITS  = mbet_pkg::FRAC_BITS_DEF,
	parameter int INDEX_BITS = mbet_pkg::INDEX_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mbet_pkg::cfg_t                   cfg,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  logic signed [INDEX_BITS+32:0]    q_cr,
	input  logic signed [INDEX_BITS+32:0]    q_ci,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mbet_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                             m_tuser
);

	localparam int F   = FRAC_BITS;
	localparam int CCW = INDEX_BITS + 33;
	localparam int ZW  = ((CCW > F + 5) ? CCW : F + 5) + 1;
	localparam int MW  = F + 2;
	localparam int CNW = mbet_pkg::COUNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ABS  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_COMB = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [ZW-1:0]   Z_TWO = {{(ZW-F-2){1'b0}}, 1'b1, {(F+1){1'b0}}};
	localparam logic [2*MW:0]   THR   = {2'b00, 1'b1, {(2*F+2){1'b0}}};
	localparam logic [MW-1:0]   M_TWO = {1'b1, {(F+1){1'b0}}};

	logic [2:0]            state_q;
	logic signed [CCW-1:0] cr_q, ci_q;
	logic signed [ZW-1:0]  zr_q, zi_q;
	logic [MW-1:0]         ar_q, ai_q;
	logic                  neg_q;
	logic [CNW-1:0]        cnt_q, esc_q;
	logic                  inside_q;
	logic                  out_valid_q, inside_out_q;
	logic [mbet_pkg::SHADE_W-1:0] shade_out_q;
	logic [CNW-1:0]        count_out_q;

	logic [ZW-1:0]         abs_r, abs_i;
	logic                  big;
	logic                  mul_start, mul_done;
	logic [2*MW-1:0]       rr, ii, ri;
	logic [2*MW:0]         magsum;
	logic                  mag_esc, at_limit, out_free;
	logic signed [2*MW:0]  diff, tr_sh;
	logic signed [F+4:0]   tr_n;
	logic signed [2*MW+1:0] rp, rs, rtw, ti_sh;
	logic signed [F+5:0]   ti_n;
	logic signed [ZW-1:0]  nr, ni;

	assign abs_r = zr_q[ZW-1] ? ZW'(-zr_q) : ZW'(zr_q);
	assign abs_i = zi_q[ZW-1] ? ZW'(-zi_q) : ZW'(zi_q);
	assign big   = (abs_r > Z_TWO) || (abs_i > Z_TWO);

	assign mul_start = (state_q == ST_ABS) && !big;

	mbet_mul #(.MW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (ar_q),
		.b      (ai_q),
		.done   (mul_done),
		.aa     (rr),
		.bb     (ii),
		.ab     (ri)
	);

	assign magsum   = {1'b0, rr} + {1'b0, ii};
	assign mag_esc  = magsum > THR;
	assign at_limit = cnt_q == cfg.iteration_limit;

	assign diff  = $signed({1'b0, rr}) - $signed({1'b0, ii});
	assign tr_sh = diff >>> F;
	assign tr_n  = tr_sh[F+4:0];
	assign nr    = ZW'(tr_n) + ZW'(cr_q);

	assign rp    = $signed({2'b00, ri});
	assign rs    = neg_q ? -rp : rp;
	assign rtw   = rs <<< 1;
	assign ti_sh = rtw >>> F;
	assign ti_n  = ti_sh[F+5:0];
	assign ni    = ZW'(ti_n) + ZW'(ci_q);

	assign out_free = !out_valid_q || m_tready;
	assign q_ready  = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (q_valid) state_q <= ST_ABS;
				ST_ABS:  state_q <= big ? ST_FIN : ST_MUL;
				ST_MUL:  if (mul_done) state_q <= ST_COMB;
				ST_COMB: state_q <= (mag_esc || at_limit) ? ST_FIN : ST_ABS;
				ST_FIN:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					cr_q  <= q_cr;
					ci_q  <= q_ci;
					zr_q  <= '0;
					zi_q  <= '0;
					cnt_q <= '0;
				end
			end
			ST_ABS: begin
				ar_q  <= abs_r[MW-1:0];
				ai_q  <= abs_i[MW-1:0];
				neg_q <= zr_q[ZW-1] ^ zi_q[ZW-1];
				if (big) begin
					esc_q    <= cnt_q - CNW'(1);
					inside_q <= 1'b0;
				end
			end
			ST_MUL: begin
			end
			ST_COMB: begin
				priority if (mag_esc) begin
					esc_q    <= cnt_q - CNW'(1);
					inside_q <= 1'b0;
				end else if (at_limit) begin
					esc_q    <= '0;
					inside_q <= 1'b1;
				end else begin
					zr_q  <= nr;
					zi_q  <= ni;
					cnt_q <= cnt_q + CNW'(1);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					shade_out_q  <= inside_q ? '0 :
						mbet_pkg::SHADE_MAX - 8'(esc_q[7:0] * cfg.shade_factor);
					count_out_q  <= esc_q;
					inside_out_q <= inside_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {count_out_q, shade_out_q};
	assign m_tuser  = inside_out_q;

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cnt_q <= cfg.iteration_limit)
		else $error("update count past limit");

	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL) else $error("multiply finished outside MUL");

	a_operands_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> (ar_q <= M_TWO && ai_q <= M_TWO))
		else $error("multiplier operand above two");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result beat raised outside FIN");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for mandelbrot_escape_time_pixel: beat driver, result monitor, and
// an escape-time predictor in Q35.28 with full-width products. Depends on mbet_pkg and the RTL.
module testbench;

	localparam int FRAC       = mbet_pkg::FRAC_BITS_DEF;
	localparam int IDX_W      = mbet_pkg::INDEX_BITS_DEF;
	localparam int IDLE_PCT   = 14;
	localparam int RAND_PHASES = 12;
	localparam int RAND_ITEMS  = 127;
	localparam int DRAIN_CYCLES = 64;
	localparam int TIMEOUT_NS  = 40_000_000;

	localparam logic [mbet_pkg::CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [mbet_pkg::CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} coord_t;

	typedef struct packed {
		logic                         in_set;
		logic [mbet_pkg::COUNT_W-1:0] count;
		logic [mbet_pkg::SHADE_W-1:0] shade;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [2*IDX_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mbet_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [mbet_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [mbet_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	coord_t coord_queue[$];
	pixel_t due_pixels[$];
	coord_t cur_xy;
	bit steady = 1'b0;
	int errors = 0;

	mbet_pkg::cfg_t view_cfg = '{
		origin_real:     mbet_pkg::RST_ORIGIN_REAL,
		origin_imag:     mbet_pkg::RST_ORIGIN_IMAG,
		step_real:       mbet_pkg::RST_STEP_REAL,
		step_imag:       mbet_pkg::RST_STEP_IMAG,
		iteration_limit: mbet_pkg::RST_ITER_LIMIT,
		shade_factor:    mbet_pkg::RST_SHADE_FACT
	};

	mandelbrot_escape_time_pixel dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// z <= z*z + c from zero; escape once |z|^2 > 4 on the exact squares
	function automatic pixel_t escape_time(input logic [IDX_W-1:0] col,
			input logic [IDX_W-1:0] row);
		longint cr, ci, zr, zi, nr, ni;
		logic signed [127:0] wr, wi, sq_r, sq_i, prod_ri, mag;
		pixel_t res;
		cr = longint'($signed(view_cfg.origin_real)) +
			longint'(col) * longint'(view_cfg.step_real);
		ci = longint'($signed(view_cfg.origin_imag)) +
			longint'(row) * longint'(view_cfg.step_imag);
		zr = 0;
		zi = 0;
		res = '{in_set: 1'b1, count: '0, shade: '0};
		for (int unsigned i = 0; i < view_cfg.iteration_limit; i++) begin
			wr = zr;
			wi = zi;
			sq_r = wr * wr;
			sq_i = wi * wi;
			prod_ri = wr * wi;
			nr = longint'((sq_r - sq_i) >>> FRAC) + cr;
			ni = longint'((prod_ri + prod_ri) >>> FRAC) + ci;
			zr = nr;
			zi = ni;
			wr = zr;
			wi = zi;
			mag = wr * wr + wi * wi;
			if (mag > (128'sd1 << (2 * FRAC + 2))) begin
				res.shade = 8'(32'd255 - i * view_cfg.shade_factor);
				res.count = 16'(i);
				res.in_set = 1'b0;
				return res;
			end
		end
		return res;
	endfunction

	// driver: one coordinate beat per handshake, random gaps between beats unless steady
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				due_pixels.push_back(escape_time(cur_xy.col, cur_xy.row));
			if (!s_tvalid || s_tready) begin
				if (coord_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					cur_xy = coord_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_xy;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		pixel_t want, got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata};
				if (due_pixels.size() == 0) begin
					$display("%0t: unexpected beat shade %0d count %0d inside %0b",
						$time, got.shade, got.count, got.in_set);
					errors++;
				end else begin
					want = due_pixels.pop_front();
					if (got.shade !== want.shade) begin
						$display("%0t: shade exp %0d got %0d", $time, want.shade, got.shade);
						errors++;
					end
					if (got.count !== want.count) begin
						$display("%0t: escape_count exp %0d got %0d", $time, want.count,
							got.count);
						errors++;
					end
					if (got.in_set !== want.in_set) begin
						$display("%0t: inside_res exp %0b got %0b", $time, want.in_set,
							got.in_set);
						errors++;
					end
				end
			end
		end
	end

	task automatic wait_drained();
		while (coord_queue.size() != 0 || s_tvalid || due_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [mbet_pkg::CFG_ADDR_W-1:0] idx,
			input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		unique case (idx)
			mbet_pkg::REG_ORIGIN_REAL: view_cfg.origin_real = val;
			mbet_pkg::REG_ORIGIN_IMAG: view_cfg.origin_imag = val;
			mbet_pkg::REG_STEP_REAL:   view_cfg.step_real = val[30:0];
			mbet_pkg::REG_STEP_IMAG:   view_cfg.step_imag = val[30:0];
			mbet_pkg::REG_ITER_LIMIT:  view_cfg.iteration_limit = val[15:0];
			mbet_pkg::REG_SHADE_FACT:  view_cfg.shade_factor = val[7:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_config(input logic [31:0] o_re, o_im, st_re, st_im, lim, gray);
		wait_drained();
		write_reg(mbet_pkg::REG_ORIGIN_REAL, o_re);
		write_reg(mbet_pkg::REG_ORIGIN_IMAG, o_im);
		write_reg(mbet_pkg::REG_STEP_REAL, st_re);
		write_reg(mbet_pkg::REG_STEP_IMAG, st_im);
		write_reg(mbet_pkg::REG_ITER_LIMIT, lim);
		write_reg(mbet_pkg::REG_SHADE_FACT, gray);
		end_writes();
	endtask

	task automatic send(input int col, input int row);
		coord_queue.push_back('{row: row[IDX_W-1:0], col: col[IDX_W-1:0]});
	endtask

	function automatic int pick_index();
		if ($urandom_range(99) < 10)
			return $urandom_range(1) ? (1 << IDX_W) - 1 : 0;
		return $urandom_range((1 << IDX_W) - 1);
	endfunction

	initial begin : stimulus
		logic [31:0] o_re, o_im, st_re, st_im, lim, gray;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// power-up image: corners, cardioid and bulb points, alternating bits
		send(0, 0);
		send(4095, 4095);
		send(0, 4095);
		send(4095, 0);
		send(2730, 2048);
		send(1365, 2048);
		send(2048, 2048);
		send(3000, 2048);
		send(2730, 1365);
		send(1365, 2730);

		// extreme origins, step writes with out-of-field bits, single update
		load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1, 255);
		send(0, 0);
		send(4095, 4095);
		send(4095, 0);
		load_config(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1, 0);
		send(0, 4095);

		// zero iteration limit via masked write, plus writes to unmapped indexes
		load_config(mbet_pkg::RST_ORIGIN_REAL, mbet_pkg::RST_ORIGIN_IMAG,
			mbet_pkg::RST_STEP_REAL, mbet_pkg::RST_STEP_IMAG, 32'h0001_0000, 32'h1FF);
		write_reg(REG_SPARE_6, $urandom);
		write_reg(REG_SPARE_7, 32'hFFFF_FFFF);
		end_writes();
		send(2730, 2048);
		send(0, 0);

		// shade wrap near the set boundary
		load_config(mbet_pkg::RST_ORIGIN_REAL, mbet_pkg::RST_ORIGIN_IMAG,
			mbet_pkg::RST_STEP_REAL, mbet_pkg::RST_STEP_IMAG, 300, 255);
		send(3415, 2048);
		send(2731, 3450);
		send(1000, 2600);
		send(3380, 2200);

		// slow escape just right of the cusp with the widest limit
		load_config(32'h0400_0100, 0, 1, 0, 32'hFFFF_FFFF, 3);
		send(3840, 4095);

		// c = 0 never escapes: full-length run
		load_config(0, 0, 0, 0, 32'h0000_FFFF, 7);
		send(5, 9);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if ($urandom_range(99) < 75) begin
				o_re = -671088640 + int'($urandom_range(0, 805306368));
				o_im = -402653184 + int'($urandom_range(0, 402653184));
				st_re = $urandom_range(99) < 20 ? $urandom_range(1, 63) : $urandom_range(64, 262144);
				st_im = $urandom_range(99) < 20 ? $urandom_range(1, 63) : $urandom_range(64, 262144);
				lim = $urandom_range(99) < 75 ? $urandom_range(1, 96) : $urandom_range(97, 300);
			end else begin
				o_re = $urandom;
				o_im = $urandom;
				st_re = $urandom;
				st_im = $urandom;
				lim = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom_range(0, 64))};
			end
			gray = {$urandom_range(1) ? 24'hFFFFFF : 24'h0, 8'($urandom_range(255))};
			load_config(o_re, o_im, st_re, st_im, lim, gray);
			steady = (ph == 4);
			repeat (RAND_ITEMS) send(pick_index(), pick_index());
		end

		wait_drained();
		steady = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("mandelbrot_escape_time_pixel verification clean");
		else
			$display("mandelbrot_escape_time_pixel verification failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("mandelbrot_escape_time_pixel verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/mbet_pkg.sv
rtl/core/mbet_front.sv
rtl/core/mbet_queue.sv
rtl/core/mbet_mul.sv
rtl/core/mbet_iter.sv
rtl/core/mandelbrot_escape_time_pixel.sv
dv/testbench.sv
